### rtl/ntwa_pkg.sv
package ntwa_pkg;

    // function codes carried in s_tuser
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_PRUNE  = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    // result status codes carried in m_tuser
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_INSERTED = 3'd1;
    localparam logic [2:0] STS_REJECTED = 3'd2;
    localparam logic [2:0] STS_FULL     = 3'd3;
    localparam logic [2:0] STS_NOTFOUND = 3'd4;

    // configuration register indexes
    localparam logic REG_LOCAL_ID    = 1'b0;
    localparam logic REG_AGE_TIMEOUT = 1'b1;

    localparam logic [30:0] AGE_TIMEOUT_RESET = 31'd5000;

    localparam int IN_DATA_W   = 64;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 48;
    localparam int OUT_USER_W  = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic apply;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic needs_scan;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

### rtl/neighbor_table_with_aging_core.sv
// neighbor table with two-stage aging. keeps TABLE_DEPTH neighbor identifiers, each with an
// active mark and a last-seen time. s_tuser selects the function: add/refresh, prune pass or
// lookup. add, prune and a lookup of a nonzero identifier walk the table one entry per cycle
// through the single read port of the identifier and time memories; a rejected add, a lookup
// of zero and the unused function code skip the walk and go straight to the apply step. one
// item is worked on at a time; its result sits in an output register and the next item is
// taken while that result waits. per-entry valid flops clear the table at reset at once, so
// no clearing pass follows reset. configuration is to be written over the apb port only while
// idle; the block itself does not enforce this.
module neighbor_table_with_aging_core
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    // input item transfer
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // neighbor_id[31:0], timestamp[63:32]
    input  logic [1:0]  s_tuser,    // func[1:0]

    // result item transfer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // slot[3:0], entry_active[4], seen_time[36:5],
                                    // known_count[41:37], live_count[46:42], zero[47]
    output logic [2:0]  m_tuser,    // status[2:0]

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] local_id_reg;
    logic [30:0] age_timeout_reg;
    logic        cfg_write;

    ntwa_pkg::ctrl_cmd_t cmd;
    ntwa_pkg::ctrl_sts_t sts;

    // registers at byte offsets 0 and 4, selected by paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_id_reg    <= 32'd0;
            age_timeout_reg <= ntwa_pkg::AGE_TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                ntwa_pkg::REG_LOCAL_ID:    local_id_reg    <= pwdata;
                ntwa_pkg::REG_AGE_TIMEOUT: age_timeout_reg <= pwdata[30:0];
                default:                   local_id_reg    <= local_id_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ntwa_pkg::REG_LOCAL_ID:    prdata = local_id_reg;
            ntwa_pkg::REG_AGE_TIMEOUT: prdata = {1'b0, age_timeout_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // sequencer: idle, table walk, apply, result hand-off
    ntwa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table memories, marks, counts, search and result registers
    ntwa_datapath
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .local_id    (local_id_reg),
        .age_timeout (age_timeout_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

### rtl/ntwa_ctrl.sv
module ntwa_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  ntwa_pkg::ctrl_sts_t   sts,
    output ntwa_pkg::ctrl_cmd_t   cmd
);

    ntwa_pkg::state_t state_reg;
    ntwa_pkg::state_t state_next;
    logic             accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ntwa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ntwa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sts.needs_scan ? ntwa_pkg::ST_SCAN : ntwa_pkg::ST_APPLY;
                end
            end
            ntwa_pkg::ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ntwa_pkg::ST_APPLY;
                end
            end
            ntwa_pkg::ST_APPLY:
            begin
                state_next = ntwa_pkg::ST_RESP;
            end
            ntwa_pkg::ST_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = ntwa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ntwa_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.scan     = 1'b0;
        cmd.apply    = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ntwa_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ntwa_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ntwa_pkg::ST_APPLY:
            begin
                cmd.apply = 1'b1;
            end
            ntwa_pkg::ST_RESP:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // scan leaves only once the last entry has been evaluated
    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ntwa_pkg::ST_SCAN && state_next != ntwa_pkg::ST_SCAN) |-> sts.scan_last)
        else $error("scan left early");

    // an accepted item that needs no table walk goes straight to the apply step
    a_apply_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !sts.needs_scan) |=> state_reg == ntwa_pkg::ST_APPLY)
        else $error("short item did not go to apply");

    // a result is only produced while no new item is taken
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !s_tready)
        else $error("result load while accepting");

endmodule

### rtl/ntwa_datapath.sv
module ntwa_datapath
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ntwa_pkg::ctrl_cmd_t               cmd,
    output ntwa_pkg::ctrl_sts_t               sts,
    input  logic [ntwa_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [ntwa_pkg::IN_USER_W-1:0]    s_tuser,
    input  logic [31:0]                       local_id,
    input  logic [30:0]                       age_timeout,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ntwa_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [ntwa_pkg::OUT_USER_W-1:0]   m_tuser
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNTW = AW + 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);

    // captured item
    logic [1:0]  func_reg;
    logic [31:0] id_reg;
    logic [31:0] ts_reg;

    // table storage
    logic [31:0] ident_mem [TABLE_DEPTH];
    logic [31:0] seen_mem  [TABLE_DEPTH];
    logic [31:0] ident_q;
    logic [31:0] seen_q;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] live_reg;
    logic [CW-1:0] known_cnt_reg;
    logic [CW-1:0] live_cnt_reg;

    // walk
    logic [CNTW-1:0] cnt_reg;
    logic [AW-1:0]   rd_idx_reg;
    logic            rd_vld_reg;
    logic            issue;

    // search trackers
    logic            match_found_reg;
    logic [AW-1:0]   match_idx_reg;
    logic            empty_found_reg;
    logic [AW-1:0]   empty_idx_reg;
    logic [31:0]     hit_seen_reg;

    // result and output registers
    logic [2:0]  res_status_reg;
    logic [AW-1:0] res_slot_reg;
    logic        res_act_reg;
    logic [31:0] res_seen_reg;
    logic        out_valid_reg;
    logic [ntwa_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [ntwa_pkg::OUT_USER_W-1:0] out_user_reg;

    logic [1:0]  in_func;
    logic [31:0] in_id;
    logic        ent_valid;
    logic        ent_live;
    logic [31:0] ent_seen;
    logic [31:0] age;
    logic [31:0] twice;
    logic        is_match;
    logic        rejected;
    logic        do_deact;
    logic        do_wipe;
    logic [AW-1:0] wr_idx;
    logic        add_write;

    assign in_func = s_tuser;
    assign in_id   = s_tdata[31:0];

    always_comb
    begin
        sts.needs_scan = 1'b0;
        case (in_func)
            ntwa_pkg::FUNC_ADD:    sts.needs_scan = (in_id != 32'd0) && (in_id != local_id);
            ntwa_pkg::FUNC_PRUNE:  sts.needs_scan = 1'b1;
            ntwa_pkg::FUNC_LOOKUP: sts.needs_scan = (in_id != 32'd0);
            default:               sts.needs_scan = 1'b0;
        endcase
    end

    assign sts.scan_last = (cnt_reg == CNTW'(TABLE_DEPTH));
    assign sts.out_free  = !out_valid_reg || m_tready;
    assign issue         = cmd.scan && (cnt_reg < CNTW'(TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= s_tuser;
            id_reg   <= s_tdata[31:0];
            ts_reg   <= s_tdata[63:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
        end
        else
        begin
            rd_vld_reg <= issue;
            rd_idx_reg <= cnt_reg[AW-1:0];
            if (cmd.capture)
            begin
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
            end
        end
    end

    // entry under evaluation; invalid entries read as all zero
    assign ent_valid = valid_reg[rd_idx_reg];
    assign ent_live  = live_reg[rd_idx_reg];
    assign ent_seen  = ent_valid ? seen_q : 32'd0;
    assign age       = ts_reg - ent_seen;
    assign twice     = {age_timeout, 1'b0};
    assign is_match  = ent_valid && (ident_q == id_reg);
    assign do_deact  = rd_vld_reg && (func_reg == ntwa_pkg::FUNC_PRUNE) && ent_live
                       && (age > {1'b0, age_timeout});
    assign do_wipe   = rd_vld_reg && (func_reg == ntwa_pkg::FUNC_PRUNE) && !ent_live
                       && ent_valid && (age > twice);

    assign rejected  = (id_reg == 32'd0) || (id_reg == local_id);
    assign wr_idx    = match_found_reg ? match_idx_reg : empty_idx_reg;
    assign add_write = cmd.apply && (func_reg == ntwa_pkg::FUNC_ADD) && !rejected
                       && (match_found_reg || empty_found_reg);

    // single read port during the walk, one write port on apply
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            ident_q <= ident_mem[cnt_reg[AW-1:0]];
            seen_q  <= seen_mem[cnt_reg[AW-1:0]];
        end
        if (add_write)
        begin
            ident_mem[wr_idx] <= id_reg;
            seen_mem[wr_idx]  <= ts_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            match_found_reg <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (is_match && !match_found_reg)
            begin
                match_found_reg <= 1'b1;
            end
            if (!ent_valid && !empty_found_reg)
            begin
                empty_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg && is_match && !match_found_reg)
        begin
            match_idx_reg <= rd_idx_reg;
            hit_seen_reg  <= seen_q;
        end
        if (rd_vld_reg && !ent_valid && !empty_found_reg)
        begin
            empty_idx_reg <= rd_idx_reg;
        end
    end

    // valid and active marks with running counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            live_reg      <= '0;
            known_cnt_reg <= '0;
            live_cnt_reg  <= '0;
        end
        else
        begin
            if (do_deact)
            begin
                live_reg[rd_idx_reg] <= 1'b0;
                live_cnt_reg         <= live_cnt_reg - CW'(1);
            end
            else if (do_wipe)
            begin
                valid_reg[rd_idx_reg] <= 1'b0;
                known_cnt_reg         <= known_cnt_reg - CW'(1);
            end
            if (add_write)
            begin
                live_reg[wr_idx] <= 1'b1;
                if (!live_reg[wr_idx])
                begin
                    live_cnt_reg <= live_cnt_reg + CW'(1);
                end
                if (!match_found_reg)
                begin
                    valid_reg[wr_idx] <= 1'b1;
                    known_cnt_reg     <= known_cnt_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            res_status_reg <= ntwa_pkg::STS_OK;
            res_slot_reg   <= '0;
            res_act_reg    <= 1'b0;
            res_seen_reg   <= 32'd0;
            case (func_reg)
                ntwa_pkg::FUNC_ADD:
                begin
                    if (rejected)
                    begin
                        res_status_reg <= ntwa_pkg::STS_REJECTED;
                    end
                    else if (match_found_reg)
                    begin
                        res_slot_reg <= match_idx_reg;
                    end
                    else if (empty_found_reg)
                    begin
                        res_status_reg <= ntwa_pkg::STS_INSERTED;
                        res_slot_reg   <= empty_idx_reg;
                    end
                    else
                    begin
                        res_status_reg <= ntwa_pkg::STS_FULL;
                    end
                end
                ntwa_pkg::FUNC_LOOKUP:
                begin
                    if (match_found_reg)
                    begin
                        res_slot_reg <= match_idx_reg;
                        res_act_reg  <= live_reg[match_idx_reg];
                        res_seen_reg <= hit_seen_reg;
                    end
                    else
                    begin
                        res_status_reg <= ntwa_pkg::STS_NOTFOUND;
                    end
                end
                default:
                begin
                    res_status_reg <= ntwa_pkg::STS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_user_reg <= res_status_reg;
            out_data_reg <= {1'b0, 5'(live_cnt_reg), 5'(known_cnt_reg), res_seen_reg,
                             res_act_reg, 4'(res_slot_reg)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_live_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg & ~valid_reg) == '0)
        else $error("active mark on an empty entry");

    a_known_count: assert property (@(posedge clk) disable iff (!rst_n)
        known_cnt_reg == CW'($countones(valid_reg)))
        else $error("known count out of step");

    a_live_count: assert property (@(posedge clk) disable iff (!rst_n)
        live_cnt_reg == CW'($countones(live_reg)))
        else $error("live count out of step");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before transfer");

endmodule

### verif/neighbor_table_with_aging_core_test.sv
`timescale 1ns / 1ps

module neighbor_table_with_aging_core_test;

    localparam int DEPTH = 16;
    localparam int POOL_SIZE = 24;
    // the block walks the table for each item; this leaves ample room before a register write
    localparam int SETTLE_CYCLES = 40;
    // longest legal quiet stretch is the deliberate output hold below, far under this
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_AFTER_ITEMS = 400;
    localparam int HOLD_CYCLES = 300;

    // func 3 has no package name, the block answers it like a no-op
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_LOCAL_ID = {1'b0, ntwa_pkg::REG_LOCAL_ID, 1'b0} << 1;
    localparam logic [2:0] ADDR_AGE_TIMEOUT = {1'b0, ntwa_pkg::REG_AGE_TIMEOUT, 1'b0} << 1;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] id;
        logic [31:0] now;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic        active;
        logic [31:0] seen_time;
        logic [4:0]  known;
        logic [4:0]  live;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;      // neighbor_id[31:0], timestamp[63:32]
    logic [1:0]  s_tuser = '0;      // func[1:0]

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // slot[3:0], entry_active[4], seen_time[36:5],
                                    // known_count[41:37], live_count[46:42], zero[47]
    logic [2:0]  m_tuser;           // status[2:0]

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    neighbor_table_with_aging_core #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow copy of the neighbor table and its registers
    logic [31:0] shadow_ident [DEPTH];
    logic        shadow_live [DEPTH];
    logic [31:0] shadow_seen [DEPTH];
    logic [31:0] cfg_local_id = '0;
    logic [30:0] cfg_timeout = ntwa_pkg::AGE_TIMEOUT_RESET;

    request_t    job_queue[$];          // items waiting to be offered
    answer_t     pending_answers[$];    // predicted results, oldest first

    logic [31:0] id_pool [POOL_SIZE];
    logic [31:0] clock_now = '0;
    logic        quiet = 1'b0;          // no idling on either side when set

    int          sent_count = 0;
    int          checked_count = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          setting_count = 0;
    int          outcome_tally [5];

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at result %0d: %s got %h expected %h",
                 checked_count, what, got, want);
        error_count++;
    endtask

    // first slot holding this identifier, -1 when none
    function automatic int slot_of(input logic [31:0] id);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (shadow_ident[i] == id)
                return i;
        end
        return -1;
    endfunction

    // applies one accepted item to the shadow table and returns the answer the block owes
    function automatic answer_t table_step(input logic [1:0] func, input logic [31:0] id,
                                           input logic [31:0] now);
        answer_t     ans;
        int          k;
        logic [31:0] twice;
        logic [31:0] age;
        ans = '0;
        ans.status = ntwa_pkg::STS_OK;
        case (func)
            ntwa_pkg::FUNC_ADD:
            begin
                if (id == '0 || id == cfg_local_id)
                    ans.status = ntwa_pkg::STS_REJECTED;
                else
                begin
                    k = slot_of(id);
                    if (k >= 0)
                    begin
                        // refresh of a known neighbor
                        shadow_live[k] = 1'b1;
                        shadow_seen[k] = now;
                        ans.slot = k[3:0];
                    end
                    else
                    begin
                        k = slot_of('0);
                        if (k >= 0)
                        begin
                            shadow_ident[k] = id;
                            shadow_live[k] = 1'b1;
                            shadow_seen[k] = now;
                            ans.status = ntwa_pkg::STS_INSERTED;
                            ans.slot = k[3:0];
                        end
                        else
                            ans.status = ntwa_pkg::STS_FULL;
                    end
                end
            end
            ntwa_pkg::FUNC_PRUNE:
            begin
                twice = {cfg_timeout, 1'b0};
                for (int i = 0; i < DEPTH; i++)
                begin
                    age = now - shadow_seen[i];
                    if (shadow_live[i])
                    begin
                        if (age > {1'b0, cfg_timeout})
                            shadow_live[i] = 1'b0;
                    end
                    else if (age > twice)
                    begin
                        // empty slots get their time cleared here as well
                        shadow_ident[i] = '0;
                        shadow_seen[i] = '0;
                    end
                end
            end
            ntwa_pkg::FUNC_LOOKUP:
            begin
                k = (id == '0) ? -1 : slot_of(id);
                if (k >= 0)
                begin
                    ans.slot = k[3:0];
                    ans.active = shadow_live[k];
                    ans.seen_time = shadow_seen[k];
                end
                else
                    ans.status = ntwa_pkg::STS_NOTFOUND;
            end
            default: ;
        endcase
        for (int i = 0; i < DEPTH; i++)
        begin
            if (shadow_ident[i] != '0)
            begin
                ans.known++;
                if (shadow_live[i])
                    ans.live++;
            end
        end
        outcome_tally[ans.status]++;
        return ans;
    endfunction

    // sender: offers queued items with random gaps, holds an item until it is taken
    always @(posedge clk)
    begin
        int gap_left;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pending_answers.push_back(table_step(s_tuser, s_tdata[31:0], s_tdata[63:32]));
                sent_count <= sent_count + 1;
            end
            if (s_tvalid && !s_tready)
                ;   // item still on offer
            else if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (job_queue.size() > 0 && !quiet && $urandom_range(0, 5) == 0)
            begin
                // a random gap before the next item
                gap_left = $urandom_range(0, 15);
                s_tvalid <= 1'b0;
            end
            else if (job_queue.size() > 0)
            begin
                request_t rq;
                rq = job_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {rq.now, rq.id};
                s_tuser <= rq.func;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: checks each result transfer and throttles m_tready
    always @(posedge clk)
    begin
        int      stall_left;
        int      hold_left;
        logic    hold_done;
        answer_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_answers.size() == 0)
                    note_mismatch("unexpected result, status", 32'(m_tuser), '0);
                else
                begin
                    want = pending_answers.pop_front();
                    if (m_tuser !== want.status)
                        note_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[3:0] !== want.slot)
                        note_mismatch("slot", 32'(m_tdata[3:0]), 32'(want.slot));
                    if (m_tdata[4] !== want.active)
                        note_mismatch("entry_active", 32'(m_tdata[4]), 32'(want.active));
                    if (m_tdata[36:5] !== want.seen_time)
                        note_mismatch("seen_time", m_tdata[36:5], want.seen_time);
                    if (m_tdata[41:37] !== want.known)
                        note_mismatch("known_count", 32'(m_tdata[41:37]), 32'(want.known));
                    if (m_tdata[46:42] !== want.live)
                        note_mismatch("live_count", 32'(m_tdata[46:42]), 32'(want.live));
                    if (m_tdata[47] !== 1'b0)
                        note_mismatch("pad bit", 32'(m_tdata[47]), '0);
                end
                checked_count++;
            end
            // one long hold so the block backs up and stalls its input
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && sent_count >= HOLD_AFTER_ITEMS)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_answers.size());
        $display("FAIL");
        $finish;
    end

    task automatic apb_transfer(input logic write, input logic [2:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // write both registers, then mirror them in the shadow copy
    task automatic set_registers(input logic [31:0] local_id, input logic [30:0] timeout);
        logic [31:0] rd;
        apb_transfer(1'b1, ADDR_LOCAL_ID, local_id, rd);
        cfg_local_id = local_id;
        apb_transfer(1'b1, ADDR_AGE_TIMEOUT, {1'b0, timeout}, rd);
        cfg_timeout = timeout;
        setting_count++;
    endtask

    task automatic check_registers();
        logic [31:0] rd;
        apb_transfer(1'b0, ADDR_LOCAL_ID, '0, rd);
        if (rd !== cfg_local_id)
            note_mismatch("local_node_id readback", rd, cfg_local_id);
        apb_transfer(1'b0, ADDR_AGE_TIMEOUT, '0, rd);
        if (rd !== {1'b0, cfg_timeout})
            note_mismatch("age_timeout readback", rd, {1'b0, cfg_timeout});
    endtask

    // every offered item taken and every result back, then let the block settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (job_queue.size() != 0 || pending_answers.size() != 0 || s_tvalid);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_job(input logic [1:0] func, input logic [31:0] id,
                            input logic [31:0] now);
        request_t rq;
        rq.func = func;
        rq.id = id;
        rq.now = now;
        job_queue.push_back(rq);
    endtask

    // random traffic: mostly a small set of identifiers so the table fills, refreshes
    // and ages; time moves on in steps scaled to the timeout
    task automatic queue_random(input int count);
        int          r;
        int unsigned span;
        logic [1:0]  func;
        logic [31:0] id;
        logic [31:0] ts;
        span = (int'(cfg_timeout) >> 2) + 16;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            func = (r < 45) ? ntwa_pkg::FUNC_ADD : (r < 63) ? ntwa_pkg::FUNC_PRUNE :
                   (r < 95) ? ntwa_pkg::FUNC_LOOKUP : FUNC_UNUSED;
            r = $urandom_range(0, 99);
            if (r < 62)
                id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (r < 67)
                id = cfg_local_id;
            else if (r < 72)
                id = '0;
            else
                id = $urandom;
            clock_now = clock_now + $urandom_range(0, span);
            ts = ($urandom_range(0, 19) == 0) ? $urandom : clock_now;
            push_job(func, id, ts);
        end
    endtask

    initial
    begin
        logic [31:0] t0;
        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_ident[i] = '0;
            shadow_live[i] = 1'b0;
            shadow_seen[i] = '0;
        end
        for (int i = 0; i < 5; i++)
            outcome_tally[i] = 0;
        id_pool[0] = 32'h0000_0001;
        id_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
        begin
            id_pool[i] = $urandom;
            if (id_pool[i] == '0)
                id_pool[i] = 32'h8000_0000;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset values of the registers
        check_registers();

        // directed part, registers at reset: local id 0, timeout 5000
        t0 = 32'd1000;
        push_job(ntwa_pkg::FUNC_ADD, '0, t0);                   // identifier zero rejected
        push_job(ntwa_pkg::FUNC_LOOKUP, '0, t0);                // lookup of zero never matches
        push_job(FUNC_UNUSED, 32'hFFFF_FFFF, '0);               // unused code, no change
        push_job(ntwa_pkg::FUNC_PRUNE, 32'hFFFF_FFFF, t0);      // prune of an empty table
        push_job(ntwa_pkg::FUNC_ADD, 32'hFFFF_FFFF, t0);        // insert into slot 0
        push_job(ntwa_pkg::FUNC_ADD, 32'h0000_0001, t0 + 1);
        push_job(ntwa_pkg::FUNC_ADD, 32'hFFFF_FFFF, t0 + 2);    // refresh
        push_job(ntwa_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, '0);     // hit
        push_job(ntwa_pkg::FUNC_LOOKUP, 32'h1234_5678, '0);     // miss
        for (int i = 0; i < DEPTH - 2; i++)
            push_job(ntwa_pkg::FUNC_ADD, 32'h100 + i, t0 + 2);
        push_job(ntwa_pkg::FUNC_ADD, 32'hABCD_EF01, t0 + 2);    // table full
        push_job(ntwa_pkg::FUNC_PRUNE, '0, t0 + 5003);          // every entry goes inactive
        push_job(ntwa_pkg::FUNC_PRUNE, '0, t0 + 10003);         // past twice the timeout: wiped
        push_job(ntwa_pkg::FUNC_ADD, 32'h0000_0055, 32'hFFFF_FFFF);
        push_job(ntwa_pkg::FUNC_PRUNE, '0, 32'd5);              // age across the wrap stays small
        clock_now = 32'd5;
        queue_random(250);
        wait_drained();

        // zero timeout: any nonzero age ages an entry out
        set_registers(id_pool[5], '0);
        check_registers();
        push_job(ntwa_pkg::FUNC_ADD, cfg_local_id, clock_now);  // own identifier rejected
        push_job(ntwa_pkg::FUNC_LOOKUP, cfg_local_id, clock_now);
        queue_random(260);
        wait_drained();

        // largest settings
        set_registers(32'hFFFF_FFFF, 31'h7FFF_FFFF);
        check_registers();
        push_job(ntwa_pkg::FUNC_ADD, 32'hFFFF_FFFF, clock_now);
        push_job(ntwa_pkg::FUNC_PRUNE, '0, clock_now - 32'd1);  // age of all ones
        queue_random(260);
        wait_drained();

        set_registers($urandom, 31'($urandom_range(50, 3000)));
        check_registers();
        queue_random(260);
        wait_drained();

        // last stretch at full rate on both sides
        quiet <= 1'b1;
        set_registers('0, ntwa_pkg::AGE_TIMEOUT_RESET);
        check_registers();
        queue_random(260);
        wait_drained();

        $display("covered %0d items under %0d register settings and reset values",
                 sent_count, setting_count);
        $display("%0d results: ok %0d, inserted %0d, rejected %0d, full %0d, not found %0d",
                 checked_count, outcome_tally[0], outcome_tally[1], outcome_tally[2],
                 outcome_tally[3], outcome_tally[4]);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
